>>> rtl/core/caldate_pkg.sv
// Package for the Gregorian calendar date counter: field widths, command and
// status codes, register indexes, and leap-year and month-length helpers.
// No dependencies.
package caldate_pkg;

    // Field widths
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    // Stream payload widths; data widths padded to whole bytes
    localparam int S_DATA_W = 24;
    localparam int S_USER_W = OP_W;
    localparam int M_DATA_W = 32;

    // Configuration port widths
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Reset values
    localparam logic [DAY_W-1:0]   DAY_RST   = 5'd1;
    localparam logic [MONTH_W-1:0] MONTH_RST = 4'd1;
    localparam logic [YEAR_W-1:0]  YEAR_RST  = 14'd2000;

    // Month constants
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_LAST  = 5'd31;

    // Command codes
    typedef enum logic [OP_W-1:0] {
        OP_LOAD = 2'd0,
        OP_NEXT = 2'd1,
        OP_PREV = 2'd2
    } op_t;

    // Status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_LIMIT   = 2'd2
    } status_t;

    // Register indexes (word address)
    typedef enum logic [1:0] {
        REG_DEFAULT_DAY   = 2'd0,
        REG_DEFAULT_MONTH = 2'd1,
        REG_DEFAULT_YEAR  = 2'd2
    } reg_idx_t;

    // Leap test: divisible by 4, and not by 100 unless by 400.
    // Divisibility of year/4 by 25 uses the modular inverse of 25 mod 2^12:
    // x is a multiple of 25 exactly when x*3113 mod 4096 <= 163.
    function automatic logic is_leap(input logic [YEAR_W-1:0] year);
        logic [YEAR_W-3:0] quarter;
        logic [YEAR_W-3:0] prod;
        logic              div4;
        logic              div100;
        logic              div400;
        quarter = year[YEAR_W-1:2];
        prod    = quarter * 12'd3113;
        div4    = (year[1:0] == 2'd0);
        div100  = div4 && (prod <= 12'd163);
        div400  = div100 && (year[3:0] == 4'd0);
        return div4 && (!div100 || div400);
    endfunction

    // Days in a month; zero for a month code outside 1..12
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic [YEAR_W-1:0]  year);
        logic [DAY_W-1:0] len;
        case (month)
            4'd2:                                    len = is_leap(year) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:                 len = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            default:                                 len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

>>> rtl/core/calendar_date_counter.sv
// A result is registered and appears on the master side in the cycle after its command is accepted.
// Throughput: one command per cycle; a command is taken while the previous result
// is handed off, and held back only while the output register is full and stalled.
// The date update is one pass of logic from the held date to the date registers.
// Reset (rst_n low, asynchronous): date 1/1/2000, defaults 1/1/2000, output empty.
// Top level of the Gregorian calendar date counter.
// Depends on caldate_pkg.
module calendar_date_counter #(
    parameter int YEAR_MAX = 9999
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Command stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata: load_day[4:0], load_month[8:5], load_year[22:9], zero pad[23]
    input  logic [caldate_pkg::S_DATA_W-1:0]   s_tdata,
    // s_tuser: op[1:0]
    input  logic [caldate_pkg::S_USER_W-1:0]   s_tuser,
    // Result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata: cur_day[4:0], cur_month[8:5], cur_year[22:9], status[24:23], zero pad[31:25]
    output logic [caldate_pkg::M_DATA_W-1:0]   m_tdata,
    // Configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [caldate_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [caldate_pkg::APB_DATA_W-1:0] pwdata,
    output logic [caldate_pkg::APB_DATA_W-1:0] prdata,
    output logic                               pready
);
    import caldate_pkg::*;

    localparam logic [YEAR_W-1:0] YEAR_LIMIT = YEAR_W'(YEAR_MAX);

    // Default registers
    logic [DAY_W-1:0]   default_day_reg;
    logic [MONTH_W-1:0] default_month_reg;
    logic [YEAR_W-1:0]  default_year_reg;

    // Held date
    logic [DAY_W-1:0]   day_reg,   day_next;
    logic [MONTH_W-1:0] month_reg, month_next;
    logic [YEAR_W-1:0]  year_reg,  year_next;
    status_t            status_next;

    // Output register
    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;

    logic               s_fire;
    logic               cfg_write;
    reg_idx_t           cfg_idx;
    op_t                op;
    logic [DAY_W-1:0]   ld_day;
    logic [MONTH_W-1:0] ld_month;
    logic [YEAR_W-1:0]  ld_year;
    logic [DAY_W-1:0]   res_day;
    logic [MONTH_W-1:0] res_month;
    logic [YEAR_W-1:0]  res_year;
    logic [DAY_W-1:0]   load_len;
    logic [DAY_W-1:0]   cur_len;
    logic [MONTH_W-1:0] month_dec;
    logic [DAY_W-1:0]   prev_len;

    // Handshakes
    assign s_tready  = !out_valid_reg || m_tready;
    assign s_fire    = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign pready    = 1'b1;
    assign cfg_idx   = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    // Register readback
    always_comb
    begin
        unique case (cfg_idx)
            REG_DEFAULT_DAY:   prdata = APB_DATA_W'(default_day_reg);
            REG_DEFAULT_MONTH: prdata = APB_DATA_W'(default_month_reg);
            REG_DEFAULT_YEAR:  prdata = APB_DATA_W'(default_year_reg);
            default:           prdata = '0;
        endcase
    end

    // Unpack the command
    assign op       = op_t'(s_tuser);
    assign ld_day   = s_tdata[DAY_W-1:0];
    assign ld_month = s_tdata[DAY_W+MONTH_W-1:DAY_W];
    assign ld_year  = s_tdata[DAY_W+MONTH_W+YEAR_W-1:DAY_W+MONTH_W];

    // Resolve zero fields of a load to their defaults
    assign res_day   = (ld_day   != '0) ? ld_day   : default_day_reg;
    assign res_month = (ld_month != '0) ? ld_month : default_month_reg;
    assign res_year  = (ld_year  != '0) ? ld_year  : default_year_reg;

    assign load_len  = month_len(res_month, res_year);
    assign cur_len   = month_len(month_reg, year_reg);
    assign month_dec = MONTH_W'(month_reg - 4'd1);
    assign prev_len  = month_len(month_dec, year_reg);

    // Next date and status for the command
    always_comb
    begin
        day_next    = day_reg;
        month_next  = month_reg;
        year_next   = year_reg;
        status_next = ST_OK;
        case (op)
            OP_LOAD:
            begin
                if (load_len == '0 || res_day == '0 || res_day > load_len ||
                    res_year > YEAR_LIMIT)
                begin
                    status_next = ST_INVALID;
                end
                else
                begin
                    day_next   = res_day;
                    month_next = res_month;
                    year_next  = res_year;
                end
            end
            OP_NEXT:
            begin
                if (day_reg < cur_len)
                begin
                    day_next = DAY_W'(day_reg + 5'd1);
                end
                else if (month_reg < MONTH_DEC)
                begin
                    day_next   = DAY_FIRST;
                    month_next = MONTH_W'(month_reg + 4'd1);
                end
                else if (year_reg >= YEAR_LIMIT)
                begin
                    status_next = ST_LIMIT;
                end
                else
                begin
                    day_next   = DAY_FIRST;
                    month_next = MONTH_JAN;
                    year_next  = YEAR_W'(year_reg + 14'd1);
                end
            end
            OP_PREV:
            begin
                if (day_reg > DAY_FIRST)
                begin
                    day_next = DAY_W'(day_reg - 5'd1);
                end
                else if (month_reg > MONTH_JAN)
                begin
                    month_next = month_dec;
                    day_next   = prev_len;
                end
                else if (year_reg == '0)
                begin
                    status_next = ST_LIMIT;
                end
                else
                begin
                    year_next  = YEAR_W'(year_reg - 14'd1);
                    month_next = MONTH_DEC;
                    day_next   = DAY_LAST;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // Default registers: write on a completed APB write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_day_reg   <= DAY_RST;
            default_month_reg <= MONTH_RST;
            default_year_reg  <= YEAR_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_DEFAULT_DAY:   default_day_reg   <= pwdata[DAY_W-1:0];
                REG_DEFAULT_MONTH: default_month_reg <= pwdata[MONTH_W-1:0];
                REG_DEFAULT_YEAR:  default_year_reg  <= pwdata[YEAR_W-1:0];
                default:           ;
            endcase
        end
    end

    // Held date: update on each accepted transaction; output valid: reload whenever s_tready is high
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            day_reg       <= DAY_RST;
            month_reg     <= MONTH_RST;
            year_reg      <= YEAR_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_fire)
            begin
                day_reg   <= day_next;
                month_reg <= month_next;
                year_reg  <= year_next;
            end
            if (s_tready)
            begin
                out_valid_reg <= s_fire;
            end
        end
    end

    // Result payload: capture with the new date
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            out_data_reg <= M_DATA_W'({status_next, year_next, month_next, day_next});
        end
    end

    // Held month stays a real month
    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        month_reg >= MONTH_JAN && month_reg <= MONTH_DEC)
        else $error("held month out of range");

    // Held day stays within 1..31
    a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
        day_reg >= DAY_FIRST && day_reg <= DAY_LAST)
        else $error("held day out of range");

    // A rejected or limited command leaves the held date alone
    a_hold_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && status_next != ST_OK |=>
            $stable(day_reg) && $stable(month_reg) && $stable(year_reg))
        else $error("date changed on an error status");

    // The result shows the date held after its command
    a_result_matches: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> m_tvalid && m_tdata[DAY_W+MONTH_W+YEAR_W-1:0] ==
            {year_reg, month_reg, day_reg})
        else $error("result does not match held date");

endmodule

>>> test/calendar_date_counter_tb.sv
// Self-checking testbench for the calendar date counter: loads, day steps, register writes.
// A date predictor in this file computes each expected result.
// Depends on caldate_pkg and calendar_date_counter.
module calendar_date_counter_tb;
    import caldate_pkg::*;

    localparam int         YEAR_LIMIT  = 9999;
    localparam int         LONG_STALL  = 40;
    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         N_DIRECTED  = 36;

    // Result fields in stream order, lowest first
    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        status_t            status;
    } date_result_t;

    typedef enum logic [1:0] {
        ROW_CMD,    // command, checked against the predictor
        ROW_CHK,    // command with the result written out
        ROW_CFG     // register write: op holds the index, year the value
    } row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [1:0]         op;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        date_result_t       want;
    } step_row_t;

    localparam date_result_t NO_WANT = '{5'd0, 4'd0, 14'd0, ST_OK};

    logic                    clk      = 1'b0;
    logic                    rst_n    = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_DATA_W-1:0]     s_tdata  = '0;
    logic [S_USER_W-1:0]     s_tuser  = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_DATA_W-1:0]     m_tdata;
    logic                    psel     = 1'b0;
    logic                    penable  = 1'b0;
    logic                    pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr    = '0;
    logic [APB_DATA_W-1:0]   pwdata   = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    // Predictor state: held date and default registers
    logic [DAY_W-1:0]        cal_day   = DAY_RST;
    logic [MONTH_W-1:0]      cal_month = MONTH_RST;
    logic [YEAR_W-1:0]       cal_year  = YEAR_RST;
    logic [DAY_W-1:0]        dflt_day   = DAY_RST;
    logic [MONTH_W-1:0]      dflt_month = MONTH_RST;
    logic [YEAR_W-1:0]       dflt_year  = YEAR_RST;

    date_result_t            pending_dates[$];
    int                      src_idle_pct  = 0;
    int                      sink_idle_pct = 0;
    bit                      long_stall_req = 1'b0;
    int                      walk_left = 0;
    logic [1:0]              walk_op   = OP_NEXT;
    int                      mismatches = 0;
    int                      n_items = 0;
    int                      n_loads = 0;
    int                      n_rejected = 0;
    int                      n_limits = 0;
    int                      n_reg_writes = 0;

    step_row_t directed_steps [N_DIRECTED] = '{
        '{ROW_CHK, OP_NEXT,   5'd0,  4'd0,  14'd0,     '{5'd2,  4'd1,  14'd2000, ST_OK}},
        '{ROW_CHK, OP_PREV,   5'd0,  4'd0,  14'd0,     '{5'd1,  4'd1,  14'd2000, ST_OK}},
        '{ROW_CHK, OP_PREV,   5'd0,  4'd0,  14'd0,     '{5'd31, 4'd12, 14'd1999, ST_OK}},
        '{ROW_CHK, OP_LOAD,   5'd0,  4'd0,  14'd0,     '{5'd1,  4'd1,  14'd2000, ST_OK}},
        '{ROW_CHK, OP_LOAD,   5'd29, 4'd2,  14'd1900,  '{5'd1,  4'd1,  14'd2000, ST_INVALID}},
        '{ROW_CHK, OP_LOAD,   5'd29, 4'd2,  14'd2000,  '{5'd29, 4'd2,  14'd2000, ST_OK}},
        '{ROW_CHK, OP_NEXT,   5'd0,  4'd0,  14'd0,     '{5'd1,  4'd3,  14'd2000, ST_OK}},
        '{ROW_CHK, OP_PREV,   5'd0,  4'd0,  14'd0,     '{5'd29, 4'd2,  14'd2000, ST_OK}},
        '{ROW_CHK, OP_LOAD,   5'd31, 4'd4,  14'd2001,  '{5'd29, 4'd2,  14'd2000, ST_INVALID}},
        '{ROW_CHK, OP_LOAD,   5'd1,  4'd13, 14'd2001,  '{5'd29, 4'd2,  14'd2000, ST_INVALID}},
        '{ROW_CHK, OP_LOAD,   5'd31, 4'd15, 14'd16383, '{5'd29, 4'd2,  14'd2000, ST_INVALID}},
        '{ROW_CHK, OP_LOAD,   5'd31, 4'd12, 14'd9999,  '{5'd31, 4'd12, 14'd9999, ST_OK}},
        '{ROW_CHK, OP_NEXT,   5'd0,  4'd0,  14'd0,     '{5'd31, 4'd12, 14'd9999, ST_LIMIT}},
        '{ROW_CHK, OP_LOAD,   5'd1,  4'd8,  14'd2023,  '{5'd1,  4'd8,  14'd2023, ST_OK}},
        '{ROW_CHK, OP_PREV,   5'd0,  4'd0,  14'd0,     '{5'd31, 4'd7,  14'd2023, ST_OK}},
        '{ROW_CHK, OP_UNUSED, 5'd31, 4'd15, 14'd16383, '{5'd31, 4'd7,  14'd2023, ST_OK}},
        '{ROW_CMD, OP_LOAD,   5'd29, 4'd2,  14'd2024,  NO_WANT},
        '{ROW_CFG, REG_DEFAULT_DAY,   5'd0, 4'd0, 14'd31,   NO_WANT},
        '{ROW_CFG, REG_DEFAULT_MONTH, 5'd0, 4'd0, 14'd12,   NO_WANT},
        '{ROW_CFG, REG_DEFAULT_YEAR,  5'd0, 4'd0, 14'd9999, NO_WANT},
        '{ROW_CHK, OP_LOAD,   5'd0,  4'd0,  14'd0,     '{5'd31, 4'd12, 14'd9999, ST_OK}},
        '{ROW_CMD, OP_PREV,   5'd0,  4'd0,  14'd0,     NO_WANT},
        '{ROW_CFG, REG_DEFAULT_DAY,   5'd0, 4'd0, 14'd0,    NO_WANT},
        '{ROW_CHK, OP_LOAD,   5'd0,  4'd2,  14'd2001,  '{5'd30, 4'd12, 14'd9999, ST_INVALID}},
        '{ROW_CFG, REG_DEFAULT_DAY,   5'd0, 4'd0, 14'd1,    NO_WANT},
        '{ROW_CFG, REG_DEFAULT_MONTH, 5'd0, 4'd0, 14'd0,    NO_WANT},
        '{ROW_CHK, OP_LOAD,   5'd5,  4'd0,  14'd2001,  '{5'd30, 4'd12, 14'd9999, ST_INVALID}},
        '{ROW_CFG, REG_DEFAULT_MONTH, 5'd0, 4'd0, 14'd1,    NO_WANT},
        '{ROW_CFG, REG_DEFAULT_YEAR,  5'd0, 4'd0, 14'd0,    NO_WANT},
        '{ROW_CHK, OP_LOAD,   5'd1,  4'd1,  14'd0,     '{5'd1,  4'd1,  14'd0,    ST_OK}},
        '{ROW_CHK, OP_PREV,   5'd0,  4'd0,  14'd0,     '{5'd1,  4'd1,  14'd0,    ST_LIMIT}},
        '{ROW_CHK, OP_LOAD,   5'd29, 4'd2,  14'd0,     '{5'd29, 4'd2,  14'd0,    ST_OK}},
        '{ROW_CFG, REG_DEFAULT_YEAR,  5'd0, 4'd0, 14'd16383, NO_WANT},
        '{ROW_CHK, OP_LOAD,   5'd1,  4'd1,  14'd0,     '{5'd29, 4'd2,  14'd0,    ST_INVALID}},
        // Leap rule must follow the default year, not the zero that was loaded
        '{ROW_CFG, REG_DEFAULT_YEAR,  5'd0, 4'd0, 14'd2023, NO_WANT},
        '{ROW_CHK, OP_LOAD,   5'd29, 4'd2,  14'd0,     '{5'd29, 4'd2,  14'd0,    ST_INVALID}}
    };

    calendar_date_counter #(
        .YEAR_MAX (YEAR_LIMIT)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gregorian leap rule
    function automatic bit leap_year(input logic [YEAR_W-1:0] y);
        int unsigned v;
        v = y;
        return (v % 4 == 0) && ((v % 100 != 0) || (v % 400 == 0));
    endfunction

    function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                       input logic [YEAR_W-1:0]  y);
        case (m)
            4'd2:                                        return leap_year(y) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:                     return 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
            default:                                     return 5'd0;
        endcase
    endfunction

    // Advance the held date by one command and return the result it produces
    function automatic date_result_t apply_command(input logic [1:0]         op,
                                                   input logic [DAY_W-1:0]   ld,
                                                   input logic [MONTH_W-1:0] lm,
                                                   input logic [YEAR_W-1:0]  ly);
        date_result_t       res;
        logic [DAY_W-1:0]   d;
        logic [MONTH_W-1:0] m;
        logic [YEAR_W-1:0]  y;
        logic [DAY_W-1:0]   len;
        status_t            st;
        st = ST_OK;
        case (op)
            OP_LOAD:
            begin
                d   = (ld != 0) ? ld : dflt_day;
                m   = (lm != 0) ? lm : dflt_month;
                y   = (ly != 0) ? ly : dflt_year;
                len = days_in_month(m, y);
                if (len == 0 || d == 0 || d > len || y > YEAR_LIMIT)
                    st = ST_INVALID;
                else
                begin
                    cal_day   = d;
                    cal_month = m;
                    cal_year  = y;
                end
            end
            OP_NEXT:
            begin
                if (cal_day < days_in_month(cal_month, cal_year))
                    cal_day = cal_day + 1'b1;
                else if (cal_month < MONTH_DEC)
                begin
                    cal_day   = DAY_FIRST;
                    cal_month = cal_month + 1'b1;
                end
                else if (cal_year >= YEAR_LIMIT)
                    st = ST_LIMIT;
                else
                begin
                    cal_day   = DAY_FIRST;
                    cal_month = MONTH_JAN;
                    cal_year  = cal_year + 1'b1;
                end
            end
            OP_PREV:
            begin
                if (cal_day > DAY_FIRST)
                    cal_day = cal_day - 1'b1;
                else if (cal_month > MONTH_JAN)
                begin
                    cal_month = cal_month - 1'b1;
                    cal_day   = days_in_month(cal_month, cal_year);
                end
                else if (cal_year == 0)
                    st = ST_LIMIT;
                else
                begin
                    cal_year  = cal_year - 1'b1;
                    cal_month = MONTH_DEC;
                    cal_day   = DAY_LAST;
                end
            end
            default: ;
        endcase
        res = '{cal_day, cal_month, cal_year, st};
        return res;
    endfunction

    // Write one default register through a setup phase and an access phase
    task automatic write_reg(input reg_idx_t idx, input logic [YEAR_W-1:0] value);
        logic done;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
            done = pready;
            @(posedge clk);
        end while (!done);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // Return the bus to idle before the next transaction
        @(posedge clk);
        case (idx)
            REG_DEFAULT_DAY:   dflt_day   = value[DAY_W-1:0];
            REG_DEFAULT_MONTH: dflt_month = value[MONTH_W-1:0];
            default:           dflt_year  = value;
        endcase
        n_reg_writes++;
    endtask

    task automatic configure(input int d, input int m, input int y);
        write_reg(REG_DEFAULT_DAY, YEAR_W'(d));
        write_reg(REG_DEFAULT_MONTH, YEAR_W'(m));
        write_reg(REG_DEFAULT_YEAR, YEAR_W'(y));
    endtask

    // Drop valid and hold until every pending result has been taken
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_dates.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Offer one command, wait for its transaction, then record what it should produce
    task automatic send_command(input logic [1:0]         op,
                                input logic [DAY_W-1:0]   d,
                                input logic [MONTH_W-1:0] m,
                                input logic [YEAR_W-1:0]  y,
                                input bit                 typed,
                                input date_result_t       want);
        logic         taken;
        date_result_t predicted;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, y, m, d};
        do
        begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end while (!taken);
        predicted = apply_command(op, d, m, y);
        pending_dates.push_back(typed ? want : predicted);
        n_items++;
        if (op == OP_LOAD)
            n_loads++;
        if (predicted.status == ST_INVALID)
            n_rejected++;
        if (predicted.status == ST_LIMIT)
            n_limits++;
    endtask

    // A load near a month start or end followed by a walk across it, a random load, a step or an unused op
    task automatic pick_command(output logic [1:0]         op,
                                output logic [DAY_W-1:0]   d,
                                output logic [MONTH_W-1:0] m,
                                output logic [YEAR_W-1:0]  y);
        int               r;
        logic [DAY_W-1:0] len;
        r  = $urandom_range(0, 99);
        op = OP_UNUSED;
        d  = DAY_W'($urandom_range(0, 31));
        m  = MONTH_W'($urandom_range(0, 15));
        y  = YEAR_W'($urandom_range(0, 16383));
        if (walk_left != 0)
        begin
            walk_left--;
            op = walk_op;
        end
        else if (r < 35)
        begin
            if ($urandom_range(0, 2) == 0)
                m = $urandom_range(0, 1) ? MONTH_DEC : MONTH_JAN;
            else
                m = MONTH_W'($urandom_range(1, 12));
            case ($urandom_range(0, 4))
                0:       y = YEAR_W'($urandom_range(1, YEAR_LIMIT));
                1:       y = YEAR_W'(100 * $urandom_range(16, 99));
                2:       y = YEAR_W'(YEAR_LIMIT - $urandom_range(0, 2));
                3:       y = YEAR_W'($urandom_range(1, 4));
                default: y = '0;
            endcase
            len = days_in_month(m, (y != 0) ? y : dflt_year);
            if ($urandom_range(0, 1))
                d = DAY_W'(len - $urandom_range(0, 2));
            else
                d = DAY_W'($urandom_range(1, 2));
            op        = OP_LOAD;
            walk_op   = $urandom_range(0, 1) ? OP_NEXT : OP_PREV;
            walk_left = $urandom_range(1, 8);
        end
        else if (r < 50)
            op = OP_LOAD;
        else if (r < 95)
            op = $urandom_range(0, 1) ? OP_NEXT : OP_PREV;
    endtask

    task automatic run_random(input int count);
        logic [1:0]         op;
        logic [DAY_W-1:0]   d;
        logic [MONTH_W-1:0] m;
        logic [YEAR_W-1:0]  y;
        repeat (count)
        begin
            pick_command(op, d, m, y);
            send_command(op, d, m, y, 1'b0, NO_WANT);
        end
    endtask

    task automatic report_field(input string name, input int unsigned want_v,
                                input int unsigned got_v);
        if (want_v != got_v)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    // Drive ready, with one long hold-off on request
    initial
    begin
        forever
        begin
            if (long_stall_req)
            begin
                long_stall_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_STALL) @(posedge clk);
            end
            m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
            @(posedge clk);
        end
    end

    // Check each result transaction against the oldest pending date
    always @(negedge clk)
    begin
        date_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_dates.size() == 0)
            begin
                $display("%0t: result with nothing pending, got 0x%08h", $time, m_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_dates.pop_front();
                report_field("cur_day", want.day, m_tdata[4:0]);
                report_field("cur_month", want.month, m_tdata[8:5]);
                report_field("cur_year", want.year, m_tdata[22:9]);
                report_field("status", want.status, m_tdata[24:23]);
                report_field("padding", 0, m_tdata[31:25]);
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("%0t: timeout with %0d results pending", $time, pending_dates.size());
        $display("[calendar_date_counter] ERROR");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, then random commands with the sender idling less
        src_idle_pct  = 30;
        sink_idle_pct = 53;
        foreach (directed_steps[i])
        begin
            if (directed_steps[i].kind == ROW_CFG)
            begin
                wait_idle();
                write_reg(reg_idx_t'(directed_steps[i].op), directed_steps[i].year);
            end
            else
                send_command(directed_steps[i].op, directed_steps[i].day,
                             directed_steps[i].month, directed_steps[i].year,
                             directed_steps[i].kind == ROW_CHK, directed_steps[i].want);
        end
        wait_idle();
        configure($urandom_range(1, 31), $urandom_range(1, 12), $urandom_range(1, YEAR_LIMIT));
        run_random(570);

        // Swap idling; year zero as the default so the lower limit is reached
        wait_idle();
        src_idle_pct  = 53;
        sink_idle_pct = 30;
        configure(31, 12, 0);
        run_random(570);

        // No idling, one long receiver hold-off and one full drain mid-stream
        wait_idle();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        configure(1, 1, YEAR_LIMIT);
        run_random(150);
        long_stall_req = 1'b1;
        run_random(150);
        wait_idle();
        run_random(270);

        wait_idle();
        repeat (4) @(posedge clk);
        $display("Ran %0d commands: %0d loads (%0d rejected), %0d year-limit hits,",
                 n_items, n_loads, n_rejected, n_limits);
        $display("%0d register writes, three idling mixes; %0d mismatches",
                 n_reg_writes, mismatches);
        if (mismatches == 0)
            $display("[calendar_date_counter] OK");
        else
            $display("[calendar_date_counter] ERROR");
        $finish;
    end

endmodule
